// ===== sv/two_level_event_dispatcher_core_macros.svh =====
// assertion helpers for the dispatcher core
`ifndef TWO_LEVEL_EVENT_DISPATCHER_CORE_MACROS_SVH
`define TWO_LEVEL_EVENT_DISPATCHER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define TLED_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TLED_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tled_pkg.sv =====
package tled_pkg;

    // fixed field widths
    localparam int PORT_W     = 6;
    localparam int OP_W       = 2;
    localparam int PORT_LIMIT = 2 ** PORT_W;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 8;

    // defaults for the top level parameters
    localparam int GROUP_BITS_DEF = 8;
    localparam int GROUPS_DEF     = 8;

    typedef enum logic [OP_W-1:0] {
        OP_RAISE    = 2'd0,
        OP_MASK     = 2'd1,
        OP_UNMASK   = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic update;  // apply raise, mask or unmask
        logic snap;    // take the dispatch snapshot
        logic emit;    // load the next result into the output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;   // output register can take a result
        logic work_last;  // at most one port left in the work vector
        logic upcall;     // upcall flag
        logic sel_any;    // some group selected
    } stat_t;

endpackage

// ===== sv/two_level_event_dispatcher_core.sv =====
// Event dispatcher over a two-level pending bitmap. Each input item carries an op
// (raise, mask, unmask, dispatch) and a port; raise, mask and unmask give no
// result. A dispatch snapshots the unmasked pending ports of the selected groups,
// then emits them as the output register can take them, lowest port first, with
// m_tlast on the final one; a dispatch with nothing to deliver gives one result
// with found clear. One lowest-port pick per cycle feeds the output register
// while it can take a result. No new item is taken until the last result of a
// dispatch is loaded into the output register.
`include "two_level_event_dispatcher_core_macros.svh"

module two_level_event_dispatcher_core
    import tled_pkg::*;
#(
    parameter int GROUP_BITS = GROUP_BITS_DEF,
    parameter int GROUPS     = GROUPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // op [1:0], port [7:2]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // event_port [5:0], found [6], zero [7]
    output logic                m_tlast
);

    op_t               s_op;
    logic [PORT_W-1:0] s_port;
    cmd_t              cmd;
    stat_t             stat;
    logic [PORT_W-1:0] event_port;
    logic              found;

    // unpack the input item
    assign s_op   = op_t'(s_tdata[OP_W-1:0]);
    assign s_port = s_tdata[OP_W +: PORT_W];

    tled_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_op    (s_op),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tled_dp #(
        .GROUP_BITS (GROUP_BITS),
        .GROUPS     (GROUPS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_op         (s_op),
        .s_port       (s_port),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_event_port (event_port),
        .m_found      (found),
        .m_last       (m_tlast)
    );

    // pack the result item
    assign m_tdata = {{(M_DATA_W - PORT_W - 1){1'b0}}, found, event_port};

    // upcall flag tracks whether any group is selected
    `TLED_ASSERT_NOW(a_upcall_sel, aclk, aresetn, 1'b1, stat.upcall == stat.sel_any, "upcall flag and selector disagree")
    // no result is produced while items are being taken
    `TLED_ASSERT_NOW(a_ready_no_emit, aclk, aresetn, s_tready, !cmd.emit, "emit while accepting items")
    // a dispatch blocks the input until its results are out
    `TLED_ASSERT_NEXT(a_snap_busy, aclk, aresetn, cmd.snap, !s_tready, "input ready right after dispatch")

endmodule

// ===== sv/tled_ctrl.sv =====
module tled_ctrl
    import tled_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  op_t   s_op,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // input is taken only between dispatches
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // commands
    always_comb begin
        cmd.update = accept && (s_op != OP_DISPATCH);
        cmd.snap   = accept && (s_op == OP_DISPATCH);
        cmd.emit   = (state_reg == ST_EMIT) && stat.out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.snap) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd.emit && stat.work_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/tled_dp.sv =====
module tled_dp
    import tled_pkg::*;
#(
    parameter int GROUP_BITS = GROUP_BITS_DEF,
    parameter int GROUPS     = GROUPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  op_t               s_op,
    input  logic [PORT_W-1:0] s_port,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PORT_W-1:0] m_event_port,
    output logic              m_found,
    output logic              m_last
);

    // only ports below the 6-bit range can ever be addressed
    localparam int TOTAL = GROUPS * GROUP_BITS;
    localparam int PORTS = (TOTAL < PORT_LIMIT) ? TOTAL : PORT_LIMIT;

    logic [PORTS-1:0]  pending_reg;
    logic [PORTS-1:0]  mask_reg;
    logic [GROUPS-1:0] selector_reg;
    logic              upcall_reg;
    logic [PORTS-1:0]  work_reg;

    logic              valid_reg;
    logic [PORT_W-1:0] port_reg;
    logic              found_reg;
    logic              last_reg;

    logic [PORTS-1:0]  hit;
    logic [GROUPS-1:0] gsel;
    logic [PORTS-1:0]  sel_ports;
    logic [PORTS-1:0]  lowest;
    logic [PORT_W-1:0] low_port;
    logic [31:0]       port_ext;

    // decode the item's port into a port bit and a group bit
    assign port_ext = {{(32 - PORT_W){1'b0}}, s_port};
    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            hit[i] = (s_port == PORT_W'(i));
        end
        for (int g = 0; g < GROUPS; g++) begin
            gsel[g] = (port_ext >= 32'(g * GROUP_BITS)) &&
                      (port_ext < 32'((g + 1) * GROUP_BITS));
        end
    end

    // spread selector bits over the ports of each group
    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            sel_ports[i] = selector_reg[i / GROUP_BITS];
        end
    end

    // lowest remaining port of the work vector
    assign lowest = work_reg & (~work_reg + PORTS'(1));
    always_comb begin
        low_port = '0;
        for (int i = 0; i < PORTS; i++) begin
            if (lowest[i]) begin
                low_port = low_port | PORT_W'(i);
            end
        end
    end

    always_comb begin
        stat.out_free  = !valid_reg || m_ready;
        stat.work_last = ((work_reg & ~lowest) == '0);
        stat.upcall    = upcall_reg;
        stat.sel_any   = (selector_reg != '0);
    end

    // bitmap state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            mask_reg     <= '0;
            selector_reg <= '0;
            upcall_reg   <= 1'b0;
        end else if (cmd.update) begin
            case (s_op)
                OP_RAISE: begin
                    pending_reg  <= pending_reg | hit;
                    selector_reg <= selector_reg | gsel;
                    if (gsel != '0) begin
                        upcall_reg <= 1'b1;
                    end
                end
                OP_MASK:   mask_reg <= mask_reg | hit;
                OP_UNMASK: mask_reg <= mask_reg & ~hit;
                default:   ;
            endcase
        end else if (cmd.snap) begin
            pending_reg  <= pending_reg & ~sel_ports;
            selector_reg <= '0;
            upcall_reg   <= 1'b0;
        end
    end

    // work vector: unmasked pending ports of the selected groups
    always_ff @(posedge aclk) begin
        if (cmd.snap) begin
            work_reg <= pending_reg & ~mask_reg & sel_ports;
        end else if (cmd.emit) begin
            work_reg <= work_reg & ~lowest;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            port_reg  <= low_port;
            found_reg <= (work_reg != '0);
            last_reg  <= stat.work_last;
        end
    end

    assign m_valid      = valid_reg;
    assign m_event_port = port_reg;
    assign m_found      = found_reg;
    assign m_last       = last_reg;

endmodule
